/* rtl/eicq_pkg.sv */
package eicq_pkg;

    localparam int BLOCK_WORDS  = 512;
    localparam int QUEUE_BLOCKS = 10;
    localparam int SLOT_COUNT   = QUEUE_BLOCKS + 1;
    localparam int MEM_WORDS    = SLOT_COUNT * BLOCK_WORDS;
    localparam int ADDR_W       = $clog2(MEM_WORDS);
    localparam int POS_W        = $clog2(BLOCK_WORDS);
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int CNT_W        = $clog2(QUEUE_BLOCKS + 1);
    localparam int INDEX_SPAN   = 512;
    localparam int LAST_READ    = (BLOCK_WORDS < INDEX_SPAN ? BLOCK_WORDS : INDEX_SPAN) - 1;
    localparam int LIMIT_RESET  = 10;

    // request queue between front and back, power of two deep
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_EDGE = 2'd1,
        FUNC_READ = 2'd2
    } t_func;

    typedef struct packed {
        logic [1:0] func;
        logic [8:0] word_index;
    } t_in_req;

    typedef struct packed {
        logic [31:0] sample_value;
        logic        queue_empty;
        logic [3:0]  blocks_ready;
        logic        block_dropped;
    } t_out_req;

    // memory operation plus the status already worked out by the front
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       wdata;
        logic              queue_empty;
        logic [3:0]        blocks_ready;
        logic              block_dropped;
    } t_op;

endpackage

/* rtl/eicq_front.sv */
module eicq_front
    import eicq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic    i_push,
    input  t_in_req i_req,
    output t_op     o_op
);

    logic [3:0]        r_limit;
    logic [31:0]       r_elapsed, n_elapsed;
    logic [POS_W-1:0]  r_fill, n_fill;
    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [CNT_W-1:0]  r_count, n_count;

    logic [CNT_W-1:0]  lim;
    logic [SLOT_W:0]   fill_sum;
    logic [SLOT_W-1:0] fill_slot;
    logic [CNT_W:0]    cnt_inc;
    logic [SLOT_W:0]   drop_sum;
    logic [SLOT_W-1:0] drop_slot;
    logic [SLOT_W:0]   rel_sum;
    logic [SLOT_W-1:0] rel_slot;
    logic [CNT_W:0]    excess;

    always_comb begin
        if (r_limit == 4'd0) begin
            lim = CNT_W'(1);
        end else if (32'(r_limit) > QUEUE_BLOCKS) begin
            lim = CNT_W'(QUEUE_BLOCKS);
        end else begin
            lim = CNT_W'(r_limit);
        end
    end

    always_comb begin
        fill_sum  = (SLOT_W+1)'(r_oldest) + (SLOT_W+1)'(r_count);
        fill_slot = (32'(fill_sum) >= SLOT_COUNT) ? SLOT_W'(32'(fill_sum) - SLOT_COUNT)
                                                  : SLOT_W'(fill_sum);
        cnt_inc   = (CNT_W+1)'(r_count) + (CNT_W+1)'(1);
        excess    = cnt_inc - (CNT_W+1)'(lim);
        drop_sum  = (SLOT_W+1)'(r_oldest) + (SLOT_W+1)'(excess);
        drop_slot = (32'(drop_sum) >= SLOT_COUNT) ? SLOT_W'(32'(drop_sum) - SLOT_COUNT)
                                                  : SLOT_W'(drop_sum);
        rel_sum   = (SLOT_W+1)'(r_oldest) + (SLOT_W+1)'(1);
        rel_slot  = (32'(rel_sum) >= SLOT_COUNT) ? SLOT_W'(0) : SLOT_W'(rel_sum);
    end

    always_comb begin
        n_elapsed = r_elapsed;
        n_fill    = r_fill;
        n_oldest  = r_oldest;
        n_count   = r_count;
        o_op      = '0;
        unique case (t_func'(i_req.func))
            FUNC_TICK: begin
                if (r_elapsed != 32'hFFFF_FFFF) begin
                    n_elapsed = r_elapsed + 32'd1;
                end
            end
            FUNC_EDGE: begin
                o_op.wr    = 1'b1;
                o_op.addr  = ADDR_W'(32'(fill_slot) * BLOCK_WORDS + 32'(r_fill));
                o_op.wdata = r_elapsed;
                n_elapsed  = '0;
                if (32'(r_fill) + 1 >= BLOCK_WORDS) begin
                    n_fill = '0;
                    if (cnt_inc > (CNT_W+1)'(lim)) begin
                        n_oldest           = drop_slot;
                        n_count            = lim;
                        o_op.block_dropped = 1'b1;
                    end else begin
                        n_count = CNT_W'(cnt_inc);
                    end
                end else begin
                    n_fill = r_fill + POS_W'(1);
                end
            end
            FUNC_READ: begin
                if (r_count == '0) begin
                    o_op.queue_empty = 1'b1;
                end else begin
                    o_op.rd   = 32'(i_req.word_index) < BLOCK_WORDS;
                    o_op.addr = ADDR_W'(32'(r_oldest) * BLOCK_WORDS
                                        + 32'(i_req.word_index));
                    if (32'(i_req.word_index) >= LAST_READ) begin
                        n_oldest = rel_slot;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        o_op.blocks_ready = 4'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= 4'(LIMIT_RESET);
            r_elapsed <= '0;
            r_fill    <= '0;
            r_oldest  <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_push) begin
                r_elapsed <= n_elapsed;
                r_fill    <= n_fill;
                r_oldest  <= n_oldest;
                r_count   <= n_count;
            end
        end
    end

endmodule

/* rtl/eicq_queue.sv */
module eicq_queue
    import eicq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_op  o_op
);

    t_op               r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_full  = 32'(r_cnt) == QDEPTH;
    assign o_op    = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_op;
        end
    end

endmodule

/* rtl/eicq_back.sv */
module eicq_back
    import eicq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_op      i_op,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_rdata;
    logic        r_ov;
    t_op         r_op;

    // the read data register doubles as the output register
    assign o_pop       = i_valid && (!r_ov || !i_out_stall);
    assign o_out_valid = r_ov;

    always_comb begin
        o_out_data.sample_value  = r_op.rd ? r_rdata : 32'd0;
        o_out_data.queue_empty   = r_op.queue_empty;
        o_out_data.blocks_ready  = r_op.blocks_ready;
        o_out_data.block_dropped = r_op.block_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_pop) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op    <= i_op;
            r_rdata <= r_mem[i_op.addr];
            if (i_op.wr) begin
                r_mem[i_op.addr] <= i_op.wdata;
            end
        end
    end

endmodule

/* rtl/edge_interval_capture_queue.sv */
// edge interval capture for one pin: tick requests count microseconds
// (saturating at 32 bits), edge requests store the elapsed count into the
// block being filled and restart it, and read requests return one word of
// the oldest finished block, releasing it at the last word. one request is
// taken per cycle while the request queue has room, and each gives one
// result; a request passes through the request queue and then the
// registered read of the interval memory, and classifying a request in
// the front is combinational. the front keeps all counters and answers
// every status field at acceptance, so it only stalls when the four-entry
// request queue is full. the interval memory needs no clearing pass after
// reset: every word is written before it can be read.
module edge_interval_capture_queue
    import eicq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request side
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    // result side
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data,
    // queue limit register
    input  logic     i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    logic push;
    logic pop;
    logic q_valid;
    logic q_full;
    t_op  front_op;
    t_op  head_op;

    // requests are taken whenever the queue has room
    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    // front: counters, fill position, ring of finished blocks
    eicq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_req       (i_in_data),
        .o_op        (front_op)
    );

    // in-order queue keeps memory writes and reads in request order
    eicq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_op    (head_op)
    );

    // back: interval memory access and result register
    eicq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_op        (head_op),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/sv/edge_interval_capture_queue_tb.sv */
`timescale 1ns / 1ps

module edge_interval_capture_queue_tb;
    import eicq_pkg::*;

    // func code 3 is not an operation: the block must leave its state alone
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // each side holds back in about this many cycles of a hundred
    localparam int IDLE_PCT = 26;
    // cycles in which neither side moves a request before giving up
    localparam int STALL_LIMIT = 4000;
    // cycle window with no idling on either side
    localparam int STEADY_FROM = 500;
    localparam int STEADY_TO   = 1000;
    // drain time after the last result: request queue, memory read
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_req    i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_req   o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;

    always #5 i_clk = ~i_clk;

    edge_interval_capture_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // shadow copy of the capture state, advanced once per taken request
    // ------------------------------------------------------------------
    logic [31:0] us_count = '0;                 // microseconds since last edge
    int          fill_pos = 0;                  // next word in the block being filled
    int          head_slot = 0;                 // slot of the oldest finished block
    int          done_blocks = 0;               // finished blocks waiting
    logic [3:0]  limit_reg = LIMIT_RESET[3:0];  // queue limit as written
    logic [31:0] interval_mem [MEM_WORDS];      // only read where written

    t_in_req  request_q[$];          // requests waiting for the driver
    t_out_req interval_results_q[$]; // results owed by the block, oldest first
    int       req_total = 0;         // requests handed to the driver
    int       req_taken = 0;         // requests taken by the block
    int       mismatches = 0;
    int       cycle_no = 0;
    int       quiet_cycles = 0;
    logic     steady;

    assign steady = (cycle_no >= STEADY_FROM) && (cycle_no < STEADY_TO);

    // advance the shadow state by one request and return the result it owes
    function automatic t_out_req capture_step(t_in_req req);
        t_out_req res;
        int       slot;
        int       lim;
        res = '0;
        case (req.func)
            FUNC_TICK: begin
                // the counter sticks at all ones
                if (us_count != 32'hFFFF_FFFF) us_count = us_count + 32'd1;
            end
            FUNC_EDGE: begin
                slot = (head_slot + done_blocks) % SLOT_COUNT;
                interval_mem[slot * BLOCK_WORDS + fill_pos] = us_count;
                us_count = '0;
                fill_pos++;
                if (fill_pos >= BLOCK_WORDS) begin
                    // effective limit is clamped into 1..QUEUE_BLOCKS
                    lim = (limit_reg == 0) ? 1 :
                          (limit_reg > QUEUE_BLOCKS) ? QUEUE_BLOCKS : int'(limit_reg);
                    fill_pos = 0;
                    done_blocks++;
                    // a lowered limit may drop several blocks at once
                    if (done_blocks > lim) begin
                        head_slot = (head_slot + done_blocks - lim) % SLOT_COUNT;
                        done_blocks = lim;
                        res.block_dropped = 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                if (done_blocks == 0) begin
                    res.queue_empty = 1'b1;
                end else begin
                    if (req.word_index < BLOCK_WORDS)
                        res.sample_value = interval_mem[head_slot * BLOCK_WORDS + req.word_index];
                    // reading at or past the last word releases the block
                    if (req.word_index >= LAST_READ) begin
                        head_slot = (head_slot + 1) % SLOT_COUNT;
                        done_blocks--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.blocks_ready = done_blocks[3:0];
        return res;
    endfunction

    task automatic push_req(input logic [1:0] f, input int widx);
        t_in_req req;
        req.func       = f;
        req.word_index = widx[8:0];
        request_q.push_back(req);
        req_total++;
    endtask

    // well-formed capture traffic: mostly edges back to back with a few ticks
    // and the odd read or unused code mixed in; the word index of ticks and
    // edges is junk on purpose
    task automatic push_capture_traffic(input int edges);
        int roll;
        int ticks;
        for (int e = 0; e < edges; e++) begin
            roll = $urandom_range(0, 999);
            if (roll < 970)      ticks = 0;
            else if (roll < 995) ticks = 1;
            else                 ticks = $urandom_range(2, 6);
            repeat (ticks) push_req(FUNC_TICK, $urandom_range(0, 511));
            push_req(FUNC_EDGE, $urandom_range(0, 511));
            roll = $urandom_range(0, 199);
            if (roll < 1)      push_req(FUNC_READ, $urandom_range(0, LAST_READ - 1));
            else if (roll < 2) push_req(FUNC_UNUSED, $urandom_range(0, 511));
        end
    endtask

    // every request taken and every result back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (req_taken != req_total || interval_results_q.size() != 0);
    endtask

    // queue limit is only written with the block idle
    task automatic write_queue_limit(input logic [3:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        limit_reg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // request driver: a payload only changes when taken or not yet valid
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                interval_results_q.push_back(capture_step(i_in_data));
                req_taken++;
            end
            if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_data  <= request_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor with random back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (interval_results_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got %h",
                                 $time, o_out_data);
                    mismatches++;
                end else begin
                    want = interval_results_q.pop_front();
                    if (o_out_data.sample_value !== want.sample_value)
                        report("sample_value", want.sample_value, o_out_data.sample_value);
                    if (o_out_data.queue_empty !== want.queue_empty)
                        report("queue_empty", 32'(want.queue_empty),
                               32'(o_out_data.queue_empty));
                    if (o_out_data.blocks_ready !== want.blocks_ready)
                        report("blocks_ready", 32'(want.blocks_ready),
                               32'(o_out_data.blocks_ready));
                    if (o_out_data.block_dropped !== want.block_dropped)
                        report("block_dropped", 32'(want.block_dropped),
                               32'(o_out_data.block_dropped));
                end
            end
            i_out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog: too long with no request moving on either side
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads on an empty queue, unused code, zero and short
        // intervals, word index extremes and alternating bit patterns
        push_req(FUNC_READ, 0);
        push_req(FUNC_READ, LAST_READ);
        push_req(FUNC_UNUSED, 9'h1FF);
        push_req(FUNC_TICK, 9'h1FF);
        push_req(FUNC_TICK, 9'h0AA);
        push_req(FUNC_TICK, 9'h155);
        push_req(FUNC_EDGE, 0);
        push_req(FUNC_EDGE, 9'h1FF);
        push_req(FUNC_TICK, 0);
        push_req(FUNC_EDGE, 9'h155);
        push_req(FUNC_UNUSED, 0);
        push_req(FUNC_READ, 9'h155);
        push_req(FUNC_TICK, 9'h0AA);
        push_req(FUNC_TICK, 0);
        push_req(FUNC_EDGE, 9'h0AA);
        push_req(FUNC_READ, 9'h0AA);

        // top value clamps to QUEUE_BLOCKS: the first block finishes after
        // the four directed edges, nothing is dropped
        write_queue_limit(4'd15);
        push_capture_traffic(BLOCK_WORDS - 4);
        repeat (4) push_req(FUNC_READ, $urandom_range(0, LAST_READ - 1));

        // zero clamps up to one block: the next completion drops the oldest
        write_queue_limit(4'd0);
        push_capture_traffic(BLOCK_WORDS);
        push_req(FUNC_READ, 0);
        push_req(FUNC_READ, LAST_READ - 1);
        push_req(FUNC_READ, LAST_READ);
        repeat (2) push_req(FUNC_READ, $urandom_range(0, 511));

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && interval_results_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* edge_interval_capture_queue.f */
rtl/eicq_pkg.sv
rtl/eicq_front.sv
rtl/eicq_queue.sv
rtl/eicq_back.sv
rtl/edge_interval_capture_queue.sv
tb/sv/edge_interval_capture_queue_tb.sv
